// ===== rtl/link_load_weight_table_defines.svh =====
// assertion macros for the link load weight table
`ifndef LINK_LOAD_WEIGHT_TABLE_DEFINES_SVH
`define LINK_LOAD_WEIGHT_TABLE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LLWT_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("llwt check failed");

// next-cycle implication checked outside reset
`define LLWT_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("llwt check failed");

`endif

// ===== rtl/llwt_pkg.sv =====
package llwt_pkg;
	localparam int TableEntriesDef = 64;
	localparam int AlphaW = 17;
	localparam int ScaleW = 10;
	localparam int RatioW = 16;
	localparam int WeightW = 10;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 17;

	localparam logic [CfgIdxW-1:0] CFG_ALPHA = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_SCALE = 1'd1;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_PROBE = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_ADDED = 3'd1;
	localparam logic [2:0] EV_REMOVED = 3'd2;
	localparam logic [2:0] EV_CHANGED = 3'd3;
	localparam logic [2:0] EV_QUERY = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DUP = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_MISS = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] src_switch;
		logic [63:0] dst_switch;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] load_ratio;
		logic        load_known;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  status;
		logic [63:0] link_src_switch;
		logic [63:0] link_dst_switch;
		logic [15:0] link_src_port;
		logic [15:0] link_dst_port;
		logic [9:0]  weight_prev;
		logic [9:0]  weight_cur;
	} rsp_t;
endpackage

// ===== rtl/llwt_if.sv =====
interface llwt_req_if;
	import llwt_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface llwt_rsp_if;
	import llwt_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/link_load_weight_table.sv =====
// channel   dir  payload                       accepted when
// req       in   mode, link key, load ratio    req.valid && req.ready
// rsp       out  event, status, link, weights  rsp.valid && rsp.ready
// cfg       in   alpha_gain, weight_scale      cfg_we
// a lookup scans every slot, comparing the three key words of each valid slot until a match
// is found; a weight is computed in steps on one shared 17x17 multiplier. a remove under the
// cursor then walks the slots to the next valid one. arst_n clears valid bits, cursor and
// control; key and ratio memories are not cleared. req.ready is low from accept until the
// result is taken.
module link_load_weight_table #(
	parameter int TABLE_ENTRIES = llwt_pkg::TableEntriesDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	llwt_req_if.sink                      req,
	llwt_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [llwt_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [llwt_pkg::CfgDataW-1:0] cfg_wdata
);
	import llwt_pkg::*;
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int KW = $clog2(3 * TABLE_ENTRIES);
	localparam int CW = IW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_RREAD, S_RWAIT, S_KEYRD, S_KEYWAIT,
		S_W_MUL1, S_W_MUL2, S_W_MUL3, S_WRITE, S_CURSOR, S_DONE
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [AlphaW-1:0] alpha_q;
	logic [ScaleW-1:0] scale_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IW-1:0] cursor_q;
	logic cursor_ok_q;

	logic [63:0] keys_mem [3*TABLE_ENTRIES];
	logic [RatioW-1:0] ratio_mem [TABLE_ENTRIES];
	logic [63:0] key_rd_q;
	logic [RatioW-1:0] ratio_rd_q;
	logic [KW-1:0] kaddr;
	logic key_we;
	logic [63:0] key_wd;
	logic [IW-1:0] raddr;
	logic ratio_we;
	logic [RatioW-1:0] ratio_wd;

	logic [CW-1:0] slot_q;
	logic [1:0] word_q;
	logic match_q;
	logic found_q;
	logic [IW-1:0] hit_q;
	logic free_ok_q;
	logic [IW-1:0] free_q;

	logic [RatioW-1:0] r0_q, r1_q;
	logic wsel_q;
	logic [WeightW-1:0] w0_q, w1_q;
	logic [1:0] wstep_q;
	logic [33:0] mul_q;
	logic [17:0] lo_q;
	logic [32:0] blend_q;
	logic upd_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] scan_q;
	logic [1:0] kstep_q;
	logic [63:0] ks_q, kd_q;
	rsp_t rsp_q;
	logic rsp_v_q;

	logic [AlphaW-1:0] a_eff;
	logic [ScaleW-1:0] s_eff;
	logic [AlphaW-1:0] mul_a, mul_b;
	logic [33:0] mul_p;
	logic [63:0] cmp_word;
	logic [IW-1:0] slot_i;
	logic [16:0] diff;
	logic [26:0] diff_prod;
	logic [15:0] wratio;
	logic [IW-1:0] scan_nx;

	function automatic rsp_t echo_rsp(logic [2:0] ev, logic [2:0] st);
		return '{ev, st, req_q.src_switch, req_q.dst_switch, req_q.src_port,
			req_q.dst_port, '0, '0};
	endfunction

	assign a_eff = (alpha_q > AlphaW'(65536)) ? AlphaW'(65536) : alpha_q;
	assign s_eff = (scale_q == '0) ? ScaleW'(16) : scale_q;
	assign slot_i = slot_q[IW-1:0];
	assign wratio = wsel_q ? r1_q : r0_q;
	assign diff = (r1_q > r0_q) ? {1'b0, r1_q - r0_q} : {1'b0, r0_q - r1_q};
	assign diff_prod = 27'(diff) * 27'(s_eff);
	assign scan_nx = (scan_q == IW'(TABLE_ENTRIES - 1)) ? '0 : scan_q + 1'b1;
	assign mul_p = 34'(mul_a) * 34'(mul_b);

	always_comb begin
		unique case (word_q)
			2'd0: cmp_word = req_q.src_switch;
			2'd1: cmp_word = req_q.dst_switch;
			default: cmp_word = {32'd0, req_q.src_port, req_q.dst_port};
		endcase
	end

	// shared multiplier: step 0 a*ratio, step 1 scale*blend low, step 2 scale*blend high
	always_comb begin
		unique case (wstep_q)
			2'd0: begin
				mul_a = a_eff;
				mul_b = {1'b0, wratio};
			end
			2'd1: begin
				mul_a = AlphaW'(s_eff);
				mul_b = {1'b0, blend_q[15:0]};
			end
			default: begin
				mul_a = AlphaW'(s_eff);
				mul_b = blend_q[32:16];
			end
		endcase
	end

	always_comb begin
		kaddr = KW'(slot_i) * KW'(3) + KW'(word_q);
		key_we = 1'b0;
		key_wd = cmp_word;
		raddr = slot_i;
		ratio_we = 1'b0;
		ratio_wd = r1_q;
		if (state_q == S_WRITE && req_q.mode == MODE_ADD) begin
			key_we = 1'b1;
			kaddr = KW'(free_q) * KW'(3) + KW'(word_q);
		end else if (state_q == S_KEYRD) begin
			kaddr = KW'(cursor_q) * KW'(3) + KW'(kstep_q);
		end
		if (state_q == S_WRITE && req_q.mode == MODE_ADD && word_q == 2'd0) begin
			ratio_we = 1'b1;
			ratio_wd = '0;
			raddr = free_q;
		end else if (state_q == S_WRITE && req_q.mode == MODE_PROBE && upd_q) begin
			ratio_we = 1'b1;
			raddr = cursor_q;
		end else if (state_q == S_RREAD) begin
			raddr = (req_q.mode == MODE_PROBE) ? cursor_q : hit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) keys_mem[kaddr] <= key_wd;
		key_rd_q <= keys_mem[kaddr];
		if (ratio_we) ratio_mem[raddr] <= ratio_wd;
		ratio_rd_q <= ratio_mem[raddr];
	end

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alpha_q <= AlphaW'(32768);
			scale_q <= ScaleW'(16);
			valid_q <= '0;
			cursor_q <= '0;
			cursor_ok_q <= 1'b0;
			rsp_v_q <= 1'b0;
			slot_q <= '0;
			word_q <= '0;
			wstep_q <= '0;
			kstep_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_ALPHA: alpha_q <= cfg_wdata;
					default: scale_q <= cfg_wdata[ScaleW-1:0];
				endcase
			end
			if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && !rsp_v_q) begin
						req_q <= req.data;
						slot_q <= '0;
						word_q <= '0;
						match_q <= 1'b1;
						found_q <= 1'b0;
						free_ok_q <= 1'b0;
						upd_q <= 1'b0;
						if (req.data.mode == MODE_PROBE) begin
							r1_q <= req.data.load_known ? req.data.load_ratio : '0;
							state_q <= (cursor_ok_q && valid_q[cursor_q]) ? S_RREAD : S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				// key words are read one at a time; read issued here, compared in S_SCAN_WAIT
				S_SCAN: begin
					if (slot_q == CW'(TABLE_ENTRIES)) begin
						state_q <= S_DECIDE;
					end else begin
						if (!valid_q[slot_i] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= slot_i;
						end
						if (!valid_q[slot_i] || found_q) begin
							slot_q <= slot_q + 1'b1;
						end else begin
							state_q <= S_SCAN_WAIT;
						end
					end
				end
				S_SCAN_WAIT: begin
					if (word_q == 2'd2) begin
						word_q <= '0;
						if (match_q && key_rd_q == cmp_word) begin
							found_q <= 1'b1;
							hit_q <= slot_i;
						end
						match_q <= 1'b1;
						slot_q <= slot_q + 1'b1;
					end else begin
						match_q <= match_q && (key_rd_q == cmp_word);
						word_q <= word_q + 1'b1;
					end
					state_q <= S_SCAN;
				end
				S_DECIDE: begin
					priority if (req_q.mode == MODE_ADD) begin
						if (found_q) begin
							rsp_q <= echo_rsp(EV_NONE, ST_DUP);
							state_q <= S_DONE;
						end else if (!free_ok_q) begin
							rsp_q <= echo_rsp(EV_NONE, ST_FULL);
							state_q <= S_DONE;
						end else begin
							rsp_q <= echo_rsp(EV_ADDED, ST_OK);
							r0_q <= '0;
							wsel_q <= 1'b0;
							state_q <= S_W_MUL1;
						end
					end else if (!found_q) begin
						rsp_q <= (req_q.mode == MODE_QUERY) ? echo_rsp(EV_QUERY, ST_MISS) :
							echo_rsp(EV_NONE, ST_UNKNOWN);
						state_q <= S_DONE;
					end else begin
						rsp_q <= echo_rsp((req_q.mode == MODE_QUERY) ? EV_QUERY : EV_REMOVED,
							ST_OK);
						state_q <= S_RREAD;
					end
				end
				S_RREAD: state_q <= S_RWAIT;
				S_RWAIT: begin
					r0_q <= ratio_rd_q;
					wsel_q <= 1'b0;
					wstep_q <= '0;
					state_q <= S_W_MUL1;
				end
				S_W_MUL1: begin
					if (req_q.mode == MODE_PROBE && wsel_q == 1'b0 &&
						diff_prod < 27'd65536) begin
						rsp_q <= '0;
						scan_q <= cursor_q;
						cnt_q <= '0;
						state_q <= S_CURSOR;
					end else begin
						mul_q <= mul_p;
						wstep_q <= 2'd1;
						state_q <= S_W_MUL2;
					end
				end
				S_W_MUL2: begin
					blend_q <= 33'((33'd65536 - 33'(a_eff)) << 16) + 33'(mul_q);
					state_q <= S_W_MUL3;
				end
				// weight = (scale*hi + (scale*lo >> 16)) >> 16
				S_W_MUL3: begin
					unique case (wstep_q)
						2'd1: begin
							mul_q <= mul_p;
							wstep_q <= 2'd2;
						end
						2'd2: begin
							lo_q <= mul_q[33:16];
							mul_q <= mul_p;
							wstep_q <= 2'd3;
						end
						default: begin
							wstep_q <= '0;
							if (wsel_q) w1_q <= WeightW'((mul_q + 34'(lo_q)) >> 16);
							else w0_q <= WeightW'((mul_q + 34'(lo_q)) >> 16);
							state_q <= S_WRITE;
						end
					endcase
				end
				S_WRITE: begin
					if (req_q.mode == MODE_PROBE && !wsel_q) begin
						wsel_q <= 1'b1;
						wstep_q <= '0;
						upd_q <= 1'b1;
						state_q <= S_W_MUL1;
					end else if (req_q.mode == MODE_PROBE) begin
						kstep_q <= '0;
						state_q <= S_KEYRD;
					end else if (req_q.mode == MODE_ADD) begin
						if (word_q == 2'd2) begin
							word_q <= '0;
							valid_q[free_q] <= 1'b1;
							if (!cursor_ok_q) begin
								cursor_q <= free_q;
								cursor_ok_q <= 1'b1;
							end
							rsp_q.weight_cur <= w0_q;
							state_q <= S_DONE;
						end else begin
							word_q <= word_q + 1'b1;
						end
					end else begin
						rsp_q.weight_cur <= w0_q;
						if (req_q.mode == MODE_REMOVE) begin
							valid_q[hit_q] <= 1'b0;
							if (cursor_ok_q && cursor_q == hit_q) begin
								scan_q <= hit_q;
								cnt_q <= '0;
								state_q <= S_CURSOR;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_KEYRD: state_q <= S_KEYWAIT;
				S_KEYWAIT: begin
					if (kstep_q == 2'd0) ks_q <= key_rd_q;
					else if (kstep_q == 2'd1) kd_q <= key_rd_q;
					if (kstep_q == 2'd2) begin
						if (w1_q != w0_q) begin
							rsp_q <= '{EV_CHANGED, ST_OK, ks_q, kd_q, key_rd_q[31:16],
								key_rd_q[15:0], w0_q, w1_q};
						end else begin
							rsp_q <= '0;
						end
						scan_q <= cursor_q;
						cnt_q <= '0;
						state_q <= S_CURSOR;
					end else begin
						kstep_q <= kstep_q + 1'b1;
						state_q <= S_KEYRD;
					end
				end
				// walk to next valid slot, one slot per cycle
				S_CURSOR: begin
					if (cnt_q == CW'(TABLE_ENTRIES)) begin
						if (req_q.mode == MODE_REMOVE) begin
							cursor_ok_q <= 1'b0;
							cursor_q <= '0;
						end
						state_q <= S_DONE;
					end else if (cnt_q != '0 && valid_q[scan_q]) begin
						cursor_q <= scan_q;
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_nx;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (req_q.mode == MODE_PROBE && !cursor_ok_q) rsp_q <= '0;
					else if (req_q.mode == MODE_PROBE && !valid_q[cursor_q]) rsp_q <= '0;
					rsp_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/llwt_checker.sv =====
module llwt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input logic [9:0] rsp_weight_cur
);
	import llwt_pkg::*;
	`include "link_load_weight_table_defines.svh"
	`LLWT_ASSERT_IMP(a_busy, clk, arst_n, rsp_valid, !req_ready)
	`LLWT_ASSERT_NXT(a_accept_busy, clk, arst_n, req_valid && req_ready, !req_ready)
	`LLWT_ASSERT_IMP(a_fail_zero, clk, arst_n, rsp_valid && rsp_status != ST_OK, rsp_weight_cur == 10'd0)
endmodule

bind link_load_weight_table llwt_checker u_llwt_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
	.rsp_weight_cur(rsp.data.weight_cur)
);

// ===== tb/llwt_tb_if.sv =====
`timescale 1ns / 100ps

interface llwt_tb_cfg_if;
	import llwt_pkg::*;
	logic                we;
	logic [CfgIdxW-1:0]  idx;
	logic [CfgDataW-1:0] wdata;
endinterface

// ===== tb/link_load_weight_table_tb.sv =====
`timescale 1ns / 100ps

module link_load_weight_table_tb;
	import llwt_pkg::*;

	localparam int NENT = 64;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;

	llwt_req_if req_ch ();
	llwt_rsp_if rsp_ch ();
	llwt_tb_cfg_if cfg_ch ();

	link_load_weight_table DUT (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.cfg_we(cfg_ch.we), .cfg_idx(cfg_ch.idx), .cfg_wdata(cfg_ch.wdata)
	);

	// shadow table
	logic [63:0] tbl_src [NENT];
	logic [63:0] tbl_dst [NENT];
	logic [31:0] tbl_ports [NENT];
	logic        tbl_used [NENT];
	logic [15:0] tbl_ratio [NENT];
	int          cursor;
	logic        cursor_ok;
	logic [16:0] alpha;
	logic [9:0]  scale;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_changes = 0;
	int n_full = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	int send_gap = 0;
	int recv_gap = 0;

	// key pool so links recur
	logic [63:0] pool_src [8];
	logic [63:0] pool_dst [8];

	always #5 clk = ~clk;

	function automatic logic [63:0] eff_scale();
		return (scale == 0) ? 64'd16 : {54'd0, scale};
	endfunction

	function automatic logic [9:0] weight_of(logic [15:0] ratio);
		logic [63:0] a;
		logic [63:0] blend;
		logic [127:0] prod;
		a = (alpha > 17'd65536) ? 64'd65536 : {47'd0, alpha};
		blend = (64'd65536 - a) * 64'd65536 + a * {48'd0, ratio};
		prod = {64'd0, eff_scale()} * {64'd0, blend};
		return prod[41:32];
	endfunction

	function automatic int find_slot(logic [63:0] s, logic [63:0] d, logic [31:0] p);
		for (int i = 0; i < NENT; i++)
			if (tbl_used[i] && tbl_src[i] == s && tbl_dst[i] == d && tbl_ports[i] == p)
				return i;
		return -1;
	endfunction

	function automatic int next_used(int from);
		for (int k = 1; k <= NENT; k++)
			if (tbl_used[(from + k) % NENT])
				return (from + k) % NENT;
		return -1;
	endfunction

	function automatic rsp_t predict_link_event(req_t r);
		rsp_t o;
		int slot;
		int nx;
		logic [31:0] p;
		logic [15:0] r0;
		logic [15:0] r1;
		logic [63:0] diff;
		logic [9:0] ow;
		logic [9:0] nw;
		o = '0;
		p = {r.src_port, r.dst_port};
		o.link_src_switch = r.src_switch;
		o.link_dst_switch = r.dst_switch;
		o.link_src_port = r.src_port;
		o.link_dst_port = r.dst_port;
		case (r.mode)
			MODE_ADD: begin
				slot = -1;
				if (find_slot(r.src_switch, r.dst_switch, p) >= 0) begin
					o.event_kind = EV_NONE;
					o.status = ST_DUP;
				end else begin
					for (int i = NENT - 1; i >= 0; i--)
						if (!tbl_used[i]) slot = i;
					if (slot < 0) begin
						o.event_kind = EV_NONE;
						o.status = ST_FULL;
						n_full++;
					end else begin
						tbl_used[slot] = 1'b1;
						tbl_src[slot] = r.src_switch;
						tbl_dst[slot] = r.dst_switch;
						tbl_ports[slot] = p;
						tbl_ratio[slot] = '0;
						if (!cursor_ok) begin
							cursor = slot;
							cursor_ok = 1'b1;
						end
						o.event_kind = EV_ADDED;
						o.status = ST_OK;
						o.weight_cur = weight_of(16'd0);
					end
				end
			end
			MODE_REMOVE: begin
				slot = find_slot(r.src_switch, r.dst_switch, p);
				if (slot < 0) begin
					o.event_kind = EV_NONE;
					o.status = ST_UNKNOWN;
				end else begin
					o.event_kind = EV_REMOVED;
					o.status = ST_OK;
					o.weight_cur = weight_of(tbl_ratio[slot]);
					tbl_used[slot] = 1'b0;
					if (cursor_ok && cursor == slot) begin
						nx = next_used(slot);
						if (nx < 0) begin
							cursor_ok = 1'b0;
							cursor = 0;
						end else begin
							cursor = nx;
						end
					end
				end
			end
			MODE_QUERY: begin
				slot = find_slot(r.src_switch, r.dst_switch, p);
				o.event_kind = EV_QUERY;
				if (slot < 0)
					o.status = ST_MISS;
				else begin
					o.status = ST_OK;
					o.weight_cur = weight_of(tbl_ratio[slot]);
				end
			end
			default: begin
				o = '0;
				if (cursor_ok && tbl_used[cursor]) begin
					r0 = tbl_ratio[cursor];
					r1 = r.load_known ? r.load_ratio : 16'd0;
					diff = (r1 > r0) ? {48'd0, r1 - r0} : {48'd0, r0 - r1};
					if (diff * eff_scale() >= 64'd65536) begin
						ow = weight_of(r0);
						nw = weight_of(r1);
						tbl_ratio[cursor] = r1;
						if (nw != ow) begin
							o.event_kind = EV_CHANGED;
							o.link_src_switch = tbl_src[cursor];
							o.link_dst_switch = tbl_dst[cursor];
							o.link_src_port = tbl_ports[cursor][31:16];
							o.link_dst_port = tbl_ports[cursor][15:0];
							o.weight_prev = ow;
							o.weight_cur = nw;
							n_changes++;
						end
					end
					nx = next_used(cursor);
					if (nx >= 0) cursor = nx;
				end
			end
		endcase
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			send_gap <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
		end else if (send_gap > 0) begin
			req_ch.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_reqs.size() > 0 &&
			!(req_ch.valid && req_ch.ready && pending_reqs.size() == 0)) begin
			if (req_ch.valid && req_ch.ready) begin
				// request just taken: draw next gap
				send_gap <= $urandom_range(0, 19) * ($urandom_range(0, 3) == 0 ? 0 : 1);
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.data <= pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
			end
		end else if (req_ch.valid && req_ch.ready) begin
			req_ch.valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			expected_rsps.push_back(predict_link_event(req_ch.data));
			n_accepted++;
		end
	end

	// receiver ready and monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_off > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			recv_gap <= $urandom_range(0, 19) * ($urandom_range(0, 3) == 0 ? 0 : 1);
			rsp_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (expected_rsps.size() == 0) begin
				$error("result with nothing expected: %p", rsp_ch.data);
				errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (rsp_ch.data.event_kind !== exp_r.event_kind) begin
					$error("event_kind exp %0d got %0d", exp_r.event_kind,
						rsp_ch.data.event_kind);
					errors++;
				end
				if (rsp_ch.data.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, rsp_ch.data.status);
					errors++;
				end
				if (rsp_ch.data.link_src_switch !== exp_r.link_src_switch) begin
					$error("link_src_switch exp %h got %h", exp_r.link_src_switch,
						rsp_ch.data.link_src_switch);
					errors++;
				end
				if (rsp_ch.data.link_dst_switch !== exp_r.link_dst_switch) begin
					$error("link_dst_switch exp %h got %h", exp_r.link_dst_switch,
						rsp_ch.data.link_dst_switch);
					errors++;
				end
				if (rsp_ch.data.link_src_port !== exp_r.link_src_port) begin
					$error("link_src_port exp %h got %h", exp_r.link_src_port,
						rsp_ch.data.link_src_port);
					errors++;
				end
				if (rsp_ch.data.link_dst_port !== exp_r.link_dst_port) begin
					$error("link_dst_port exp %h got %h", exp_r.link_dst_port,
						rsp_ch.data.link_dst_port);
					errors++;
				end
				if (rsp_ch.data.weight_prev !== exp_r.weight_prev) begin
					$error("weight_prev exp %0d got %0d", exp_r.weight_prev,
						rsp_ch.data.weight_prev);
					errors++;
				end
				if (rsp_ch.data.weight_cur !== exp_r.weight_cur) begin
					$error("weight_cur exp %0d got %0d", exp_r.weight_cur,
						rsp_ch.data.weight_cur);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("link_load_weight_table regression: fail");
			$finish;
		end
	end

	function automatic req_t make_request(logic [1:0] m, int key);
		req_t r;
		r.mode = m;
		r.src_switch = pool_src[key % 8];
		r.dst_switch = pool_dst[key % 8];
		r.src_port = key[15:0];
		r.dst_port = 16'(key >> 3);
		r.load_ratio = 16'($urandom);
		r.load_known = $urandom_range(0, 7) != 0;
		return r;
	endfunction

	function automatic req_t make_noise();
		req_t r;
		r.mode = 2'($urandom);
		r.src_switch = {$urandom, $urandom};
		r.dst_switch = {$urandom, $urandom};
		r.src_port = 16'($urandom);
		r.dst_port = 16'($urandom);
		r.load_ratio = 16'($urandom);
		r.load_known = 1'($urandom);
		return r;
	endfunction

	task automatic drain();
		wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
		repeat (3 * NENT + 40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_ch.we <= 1'b1;
		cfg_ch.idx <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		cfg_ch.we <= 1'b0;
		if (idx == CFG_ALPHA) alpha = val;
		else scale = val[9:0];
	endtask

	task automatic run_phase(int n);
		int mode_pick;
		for (int i = 0; i < n; i++) begin
			mode_pick = $urandom_range(0, 99);
			if (mode_pick < 8)
				pending_reqs.push_back(make_noise());
			else if (mode_pick < 35)
				pending_reqs.push_back(make_request(MODE_ADD, $urandom_range(0, 80)));
			else if (mode_pick < 50)
				pending_reqs.push_back(make_request(MODE_REMOVE, $urandom_range(0, 80)));
			else if (mode_pick < 85)
				pending_reqs.push_back(make_request(MODE_PROBE, 0));
			else
				pending_reqs.push_back(make_request(MODE_QUERY, $urandom_range(0, 80)));
		end
	endtask

	initial begin
		req_t r;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.we = 1'b0;
		cfg_ch.idx = '0;
		cfg_ch.wdata = '0;
		for (int i = 0; i < NENT; i++) begin
			tbl_used[i] = 1'b0;
			tbl_ratio[i] = '0;
		end
		cursor = 0;
		cursor_ok = 1'b0;
		alpha = 17'd32768;
		scale = 10'd16;
		pool_src[0] = '0;
		pool_dst[0] = '0;
		pool_src[1] = '1;
		pool_dst[1] = '1;
		for (int i = 2; i < 8; i++) begin
			pool_src[i] = {$urandom, $urandom};
			pool_dst[i] = {$urandom, $urandom};
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table probe, extremes, duplicate, misses, probes
		pending_reqs.push_back(make_request(MODE_PROBE, 0));
		pending_reqs.push_back(make_request(MODE_QUERY, 1));
		pending_reqs.push_back(make_request(MODE_REMOVE, 1));
		r = make_request(MODE_ADD, 0);
		r.src_port = 16'hFFFF;
		r.dst_port = 16'hFFFF;
		pending_reqs.push_back(r);
		r = make_request(MODE_ADD, 1);
		r.src_port = '0;
		r.dst_port = '0;
		pending_reqs.push_back(r);
		pending_reqs.push_back(r);
		r.mode = MODE_PROBE;
		r.load_known = 1'b1;
		r.load_ratio = 16'hFFFF;
		pending_reqs.push_back(r);
		pending_reqs.push_back(r);
		r.load_known = 1'b0;
		pending_reqs.push_back(r);
		r.mode = MODE_QUERY;
		pending_reqs.push_back(r);
		r.mode = MODE_REMOVE;
		pending_reqs.push_back(r);
		r.mode = MODE_PROBE;
		pending_reqs.push_back(r);
		drain();

		// fill the table to full with the receiver held off
		hold_off = 3000;
		for (int i = 0; i < NENT + 2; i++)
			pending_reqs.push_back(make_request(MODE_ADD, 100 + i));
		pending_reqs.push_back(make_request(MODE_ADD, 100));
		drain();
		for (int i = 0; i < NENT + 2; i++)
			pending_reqs.push_back(make_request(MODE_REMOVE, 100 + i));
		drain();

		write_reg(CFG_ALPHA, 17'd65536);
		write_reg(CFG_SCALE, 17'd1023);
		run_phase(350);
		drain();
		write_reg(CFG_ALPHA, 17'h1FFFF);
		write_reg(CFG_SCALE, 17'd1);
		run_phase(250);
		drain();
		write_reg(CFG_ALPHA, 17'd0);
		write_reg(CFG_SCALE, 17'd0);
		run_phase(250);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_ALPHA, 17'($urandom_range(0, 65536)));
			write_reg(CFG_SCALE, 17'($urandom_range(1, 1023)));
			run_phase(175);
			drain();
		end

		$display("covered %0d requests, %0d weight changes, %0d full-table rejects",
			n_accepted, n_changes, n_full);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("link_load_weight_table regression: pass");
		else
			$display("link_load_weight_table regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/llwt_pkg.sv
rtl/llwt_if.sv
rtl/link_load_weight_table.sv
rtl/llwt_checker.sv
tb/llwt_tb_if.sv
tb/link_load_weight_table_tb.sv
